/* rtl/hrv_window_features_assert.svh */
// Assertion macros for the HRV window feature block
`ifndef HRV_WINDOW_FEATURES_ASSERT_SVH
`define HRV_WINDOW_FEATURES_ASSERT_SVH

// same-cycle implication, reset masked
`define HRV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define HRV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hrv_pkg.sv */
// Package: types and constants shared by the HRV window feature block
`default_nettype none

package hrv_pkg;

    localparam int MAX_BEATS_DEF = 128;
    localparam int MIN_BEATS     = 20;
    localparam int SQRT_W        = 32;

    localparam int CNT_W_DEF = $clog2(MAX_BEATS_DEF + 1);
    localparam int DW_DEF    = 2 * CNT_W_DEF + 33;
    localparam int MA_W_DEF  = CNT_W_DEF + 32;
    localparam int MB_W_DEF  = CNT_W_DEF + 16;

    localparam logic [15:0] RR_LOW      = 16'd4000;
    localparam logic [15:0] RR_HIGH     = 16'd40000;
    localparam logic [15:0] NN50_LIMIT  = 16'd800;
    localparam logic [21:0] WIN_DEFAULT = 22'd60000;
    localparam logic [27:0] HR_CONST    = 28'd245760000;

    localparam logic [20:0] SLOPE_POS_SAT = 21'h0FFFFF;
    localparam logic [20:0] SLOPE_NEG_SAT = 21'h100000;
    localparam int          SLOPE_LIM     = 1048576;
    localparam int          SD_SAT        = 32767;
    localparam int          U16_SAT       = 65535;
    localparam int          CV_SAT        = 32767;
    localparam int          COV_SAT       = 32768;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FULL_RD,
        S_FULL_DROP,
        S_PUSH,
        S_EVICT_RD,
        S_EVICT_CHK,
        S_FEAT,
        S_ACC,
        S_ISSUE,
        S_WAIT,
        S_DONE
    } seq_state_t;

    typedef enum logic [4:0] {
        P_NS,
        P_NIX,
        P_ISUM,
        P_NI2,
        P_II,
        P_SLOPE,
        P_NSQ,
        P_SS,
        P_NN,
        P_VAR,
        P_SD,
        P_MEAN,
        P_HRN,
        P_HR,
        P_RMSQ,
        P_RMS,
        P_PNN,
        P_CV,
        P_COV
    } post_step_t;

    typedef struct packed {
        logic        accepted;
        logic        features_valid;
        logic [15:0] mean_rr;
        logic [15:0] mean_hr;
        logic [14:0] sdnn;
        logic [15:0] rmssd;
        logic [15:0] pnn50;
        logic [20:0] rr_slope;
        logic [14:0] hr_cv;
        logic [15:0] coverage;
    } hrv_result_t;

endpackage

`default_nettype wire

/* rtl/hrv_window_features.sv */
// Time from accept to result grows with the beats held and each evicted beat, and
// is longer when the ring is full; most of it goes to the eight bit-serial divides
// of DW = 2*clog2(MAX_BEATS+1)+33 bits.
// One item at a time; not ready until the result has been taken.
// rst_n (async, active low) empties the window and sets the window to 60000 ms.
`default_nettype none

module hrv_window_features import hrv_pkg::*; #(
    parameter int MAX_BEATS = MAX_BEATS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [15:0]   s_axis_tdata,  // rr_interval
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // mean_rr, mean_hr, sdnn, rmssd, pnn50, rr_slope, hr_cv, coverage, zero pad
    output logic [135:0]       m_axis_tdata,
    output logic [1:0]         m_axis_tuser,  // accepted, features_valid
    input  wire logic          cfg_wr_en,
    input  wire logic [21:0]   cfg_wr_data    // window_length_ms
);

    `include "hrv_window_features_assert.svh"

    localparam int PTR_W = $clog2(MAX_BEATS);
    localparam int CNT_W = $clog2(MAX_BEATS + 1);
    localparam int DW    = 2 * CNT_W + 33;
    localparam int MA_W  = CNT_W + 32;
    localparam int MB_W  = CNT_W + 16;

    logic [21:0]      win_reg;
    logic             out_vld_reg, out_vld_next;
    hrv_result_t      out_res_reg;

    logic             res_valid;
    hrv_result_t      res;
    logic             ring_we;
    logic [PTR_W-1:0] ring_waddr;
    logic [15:0]      ring_wdata;
    logic [PTR_W-1:0] ring_raddr;
    logic [15:0]      ring_rdata;
    arith_ctl_t       ar_ctl;
    logic [DW-1:0]    ar_a;
    logic [DW-1:0]    ar_b;
    logic             ar_done;
    logic [DW-1:0]    ar_res;

    hrv_ring #(
        .DEPTH (MAX_BEATS),
        .PTR_W (PTR_W)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    hrv_arith #(
        .DW   (DW),
        .MA_W (MA_W),
        .MB_W (MB_W)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ar_ctl),
        .a     (ar_a),
        .b     (ar_b),
        .done  (ar_done),
        .res   (ar_res)
    );

    hrv_seq #(
        .MAX_BEATS (MAX_BEATS),
        .DW        (DW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_rr      (s_axis_tdata),
        .win_len    (win_reg),
        .out_pend   (out_vld_reg),
        .res_valid  (res_valid),
        .res        (res),
        .ring_we    (ring_we),
        .ring_waddr (ring_waddr),
        .ring_wdata (ring_wdata),
        .ring_raddr (ring_raddr),
        .ring_rdata (ring_rdata),
        .ar_ctl     (ar_ctl),
        .ar_a       (ar_a),
        .ar_b       (ar_b),
        .ar_done    (ar_done),
        .ar_res     (ar_res)
    );

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (res_valid)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= WIN_DEFAULT;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                win_reg <= cfg_wr_data;
            end
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = {out_res_reg.features_valid, out_res_reg.accepted};
    assign m_axis_tdata  = {5'b0,
                            out_res_reg.coverage,
                            out_res_reg.hr_cv,
                            out_res_reg.rr_slope,
                            out_res_reg.pnn50,
                            out_res_reg.rmssd,
                            out_res_reg.sdnn,
                            out_res_reg.mean_hr,
                            out_res_reg.mean_rr};

    `HRV_ASSERT_NOW(a_busy_when_pending, m_axis_tvalid, !s_axis_tready,
        "input ready while a result is pending")
    `HRV_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input ready right after an accepted item")
    `HRV_ASSERT_NOW(a_zero_when_invalid, m_axis_tvalid && !m_axis_tuser[1],
        m_axis_tdata == '0, "feature fields not zero without a full window")
    `HRV_ASSERT_NOW(a_ratio_caps, m_axis_tvalid,
        (m_axis_tdata[130:115] <= 16'd32768) && (m_axis_tdata[78:63] <= 16'd32768),
        "coverage or pnn50 beyond one")

endmodule

`default_nettype wire

/* rtl/hrv_ring.sv */
// Beat ring: single write port, registered read port
`default_nettype none

module hrv_ring #(
    parameter int DEPTH = 128,
    parameter int PTR_W = 7
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [PTR_W-1:0] waddr,
    input  wire logic [15:0]      wdata,
    input  wire logic [PTR_W-1:0] raddr,
    output logic      [15:0]      rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/hrv_arith.sv */
// Shared arithmetic unit: registered multiply, bit-serial divide and square root
`default_nettype none

module hrv_arith import hrv_pkg::*; #(
    parameter int DW   = DW_DEF,
    parameter int MA_W = MA_W_DEF,
    parameter int MB_W = MB_W_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire arith_ctl_t    ctl,
    input  wire logic [DW-1:0] a,
    input  wire logic [DW-1:0] b,
    output logic               done,
    output logic      [DW-1:0] res
);

    localparam int CW = $clog2(DW + 1);
    localparam int PW = MA_W + MB_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    arith_op_t     op_reg, op_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] src_reg, src_next;
    logic [DW-1:0] div_reg, div_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;

    logic [PW-1:0] prod;
    logic [DW:0]   tmp;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign prod = PW'(a[MA_W-1:0]) * PW'(b[MB_W-1:0]);

    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            tmp   = {rem_reg[DW-2:0], src_reg[DW-1:DW-2]};
            trial = {quo_reg[DW-2:0], 2'b01};
        end
        else
        begin
            tmp   = {rem_reg, src_reg[DW-1]};
            trial = {1'b0, div_reg};
        end
        ge   = (tmp >= trial);
        diff = tmp - trial;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (ctl.start)
        begin
            op_next = ctl.op;
            unique case (ctl.op)
                OP_MUL:
                begin
                    quo_next  = DW'(prod);
                    done_next = 1'b1;
                end
                OP_DIV:
                begin
                    src_next  = a;
                    div_next  = b;
                    rem_next  = '0;
                    quo_next  = '0;
                    cnt_next  = CW'(DW);
                    busy_next = 1'b1;
                end
                OP_SQRT:
                begin
                    src_next  = {a[SQRT_W-1:0], (DW-SQRT_W)'(0)};
                    rem_next  = '0;
                    quo_next  = '0;
                    cnt_next  = CW'(SQRT_W / 2);
                    busy_next = 1'b1;
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : tmp[DW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            src_next = (op_reg == OP_SQRT) ? (src_reg << 2) : (src_reg << 1);
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        src_reg <= src_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign res  = quo_reg;

endmodule

`default_nettype wire

/* rtl/hrv_seq.sv */
// Sequencer: ring upkeep, window sweep and feature post-processing
`default_nettype none

module hrv_seq import hrv_pkg::*; #(
    parameter int MAX_BEATS = MAX_BEATS_DEF,
    parameter int DW        = DW_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [15:0]                  in_rr,
    input  wire logic [21:0]                  win_len,
    input  wire logic                         out_pend,
    output logic                              res_valid,
    output hrv_result_t                       res,
    output logic                              ring_we,
    output logic [$clog2(MAX_BEATS)-1:0]      ring_waddr,
    output logic [15:0]                       ring_wdata,
    output logic [$clog2(MAX_BEATS)-1:0]      ring_raddr,
    input  wire logic [15:0]                  ring_rdata,
    output arith_ctl_t                        ar_ctl,
    output logic [DW-1:0]                     ar_a,
    output logic [DW-1:0]                     ar_b,
    input  wire logic                         ar_done,
    input  wire logic [DW-1:0]                ar_res
);

    localparam int PTR_W  = $clog2(MAX_BEATS);
    localparam int CNT_W  = $clog2(MAX_BEATS + 1);
    localparam int SUM_W  = CNT_W + 16;
    localparam int SQ_W   = CNT_W + 32;
    localparam int PP_W   = 2 * CNT_W + 16;
    localparam int SI_W   = 2 * CNT_W;
    localparam int SI2_W  = 3 * CNT_W;
    localparam int CMP_W  = (SUM_W > 26) ? SUM_W + 1 : 27;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(MAX_BEATS - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    seq_state_t       state_reg, state_next;
    post_step_t       step_reg, step_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] span_reg, span_next;
    logic             rd_vld_reg, rd_vld_next;

    logic [15:0]      rr_reg, rr_next;
    logic             acc_reg, acc_next;
    logic             fv_reg, fv_next;
    logic [PTR_W-1:0] iss_ptr_reg, iss_ptr_next;
    logic [CNT_W-1:0] iss_cnt_reg, iss_cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [SI_W-1:0]  isq_reg, isq_next;
    logic [15:0]      prev_reg, prev_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]  sumsq_reg, sumsq_next;
    logic [SQ_W-1:0]  dsq_reg, dsq_next;
    logic [PP_W-1:0]  pp_reg, pp_next;
    logic [SI_W-1:0]  sumi_reg, sumi_next;
    logic [SI2_W-1:0] sumi2_reg, sumi2_next;
    logic [CNT_W-1:0] nn50_reg, nn50_next;
    logic [DW-1:0]    t1_reg, t1_next;
    logic [DW-1:0]    t2_reg, t2_next;
    logic             neg_reg, neg_next;
    logic [15:0]      mean_reg, mean_next;
    logic [15:0]      hr_reg, hr_next;
    logic [14:0]      sd_reg, sd_next;
    logic [15:0]      rms_reg, rms_next;
    logic [15:0]      pnn_reg, pnn_next;
    logic [20:0]      slope_reg, slope_next;
    logic [14:0]      cv_reg, cv_next;
    logic [15:0]      cov_reg, cov_next;

    logic             accept;
    logic             in_range;
    logic [21:0]      win;
    logic [CMP_W-1:0] w16;
    logic [CMP_W-1:0] span_less;
    logic             evict;
    logic [15:0]      x;
    logic [31:0]      xsq;
    logic signed [16:0] d;
    logic [15:0]      ad;
    logic [31:0]      dsqt;
    logic             last_beat;
    logic [DW-1:0]    n_dw;
    logic [DW-1:0]    nm1_dw;

    assign in_ready  = (state_reg == S_IDLE) && !out_pend;
    assign accept    = in_valid && in_ready;
    assign in_range  = (in_rr >= RR_LOW) && (in_rr <= RR_HIGH);
    assign win       = (win_len == '0) ? WIN_DEFAULT : win_len;
    assign w16       = CMP_W'({win, 4'b0000});
    assign span_less = CMP_W'(span_reg) - CMP_W'(ring_rdata);
    assign evict     = (span_less > w16);
    assign x         = ring_rdata;
    assign xsq       = 32'(x) * 32'(x);
    assign d         = $signed({1'b0, x}) - $signed({1'b0, prev_reg});
    assign ad        = d[16] ? 16'(-d) : d[15:0];
    assign dsqt      = 32'(ad) * 32'(ad);
    assign last_beat = rd_vld_reg && (idx_reg == cnt_reg - CNT_W'(1));
    assign n_dw      = DW'(cnt_reg);
    assign nm1_dw    = DW'(cnt_reg) - DW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!in_range)
                    begin
                        state_next = S_FEAT;
                    end
                    else if (cnt_reg == CNT_W'(MAX_BEATS))
                    begin
                        state_next = S_FULL_RD;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_FULL_RD:   state_next = S_FULL_DROP;
            S_FULL_DROP: state_next = S_PUSH;
            S_PUSH:      state_next = S_EVICT_RD;
            S_EVICT_RD:
            begin
                state_next = (cnt_reg > CNT_W'(MIN_BEATS)) ? S_EVICT_CHK : S_FEAT;
            end
            S_EVICT_CHK: state_next = evict ? S_EVICT_RD : S_FEAT;
            S_FEAT:
            begin
                state_next = (cnt_reg >= CNT_W'(MIN_BEATS)) ? S_ACC : S_DONE;
            end
            S_ACC:
            begin
                if (last_beat)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:     state_next = S_WAIT;
            S_WAIT:
            begin
                if (ar_done)
                begin
                    state_next = (step_reg == P_COV) ? S_DONE : S_ISSUE;
                end
            end
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs to ring and arithmetic unit
    always_comb
    begin
        ring_we    = (state_reg == S_PUSH);
        ring_waddr = wp_reg;
        ring_wdata = rr_reg;
        ring_raddr = (state_reg == S_ACC) ? iss_ptr_reg : head_reg;
        res_valid  = (state_reg == S_DONE);
        ar_ctl.start = (state_reg == S_ISSUE);
        ar_ctl.op    = OP_MUL;
        ar_a         = '0;
        ar_b         = '0;
        unique case (step_reg)
            P_NS:    begin ar_a = DW'(sum_reg);   ar_b = n_dw; end
            P_NIX:   begin ar_a = t1_reg;         ar_b = n_dw; end
            P_ISUM:  begin ar_a = DW'(sumi_reg);  ar_b = DW'(sum_reg); end
            P_NI2:   begin ar_a = DW'(sumi2_reg); ar_b = n_dw; end
            P_II:    begin ar_a = DW'(sumi_reg);  ar_b = DW'(sumi_reg); end
            P_SLOPE:
            begin
                ar_ctl.op = OP_DIV;
                ar_a      = t1_reg + (t2_reg >> 1);
                ar_b      = t2_reg;
            end
            P_NSQ:   begin ar_a = DW'(sumsq_reg); ar_b = n_dw; end
            P_SS:    begin ar_a = DW'(sum_reg);   ar_b = DW'(sum_reg); end
            P_NN:    begin ar_a = n_dw;           ar_b = n_dw; end
            P_VAR:
            begin
                ar_ctl.op = OP_DIV;
                ar_a      = t1_reg;
                ar_b      = t2_reg;
            end
            P_SD:
            begin
                ar_ctl.op = OP_SQRT;
                ar_a      = t1_reg;
            end
            P_MEAN:
            begin
                ar_ctl.op = OP_DIV;
                ar_a      = DW'(sum_reg) + (n_dw >> 1);
                ar_b      = n_dw;
            end
            P_HRN:   begin ar_a = DW'(HR_CONST);  ar_b = n_dw; end
            P_HR:
            begin
                ar_ctl.op = OP_DIV;
                ar_a      = t1_reg + (DW'(sum_reg) >> 1);
                ar_b      = DW'(sum_reg);
            end
            P_RMSQ:
            begin
                ar_ctl.op = OP_DIV;
                ar_a      = DW'(dsq_reg);
                ar_b      = nm1_dw;
            end
            P_RMS:
            begin
                ar_ctl.op = OP_SQRT;
                ar_a      = t1_reg;
            end
            P_PNN:
            begin
                ar_ctl.op = OP_DIV;
                ar_a      = DW'(nn50_reg) << 15;
                ar_b      = nm1_dw;
            end
            P_CV:
            begin
                ar_ctl.op = OP_DIV;
                ar_a      = DW'(sd_reg) << 14;
                ar_b      = DW'(mean_reg);
            end
            P_COV:
            begin
                ar_ctl.op = OP_DIV;
                ar_a      = DW'(span_reg) << 15;
                ar_b      = DW'(w16);
            end
            default: ar_ctl.op = OP_MUL;
        endcase
    end

    // datapath
    always_comb
    begin
        step_next    = step_reg;
        head_next    = head_reg;
        wp_next      = wp_reg;
        cnt_next     = cnt_reg;
        span_next    = span_reg;
        rd_vld_next  = 1'b0;
        rr_next      = rr_reg;
        acc_next     = acc_reg;
        fv_next      = fv_reg;
        iss_ptr_next = iss_ptr_reg;
        iss_cnt_next = iss_cnt_reg;
        idx_next     = idx_reg;
        isq_next     = isq_reg;
        prev_next    = prev_reg;
        sum_next     = sum_reg;
        sumsq_next   = sumsq_reg;
        dsq_next     = dsq_reg;
        pp_next      = pp_reg;
        sumi_next    = sumi_reg;
        sumi2_next   = sumi2_reg;
        nn50_next    = nn50_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        neg_next     = neg_reg;
        mean_next    = mean_reg;
        hr_next      = hr_reg;
        sd_next      = sd_reg;
        rms_next     = rms_reg;
        pnn_next     = pnn_reg;
        slope_next   = slope_reg;
        cv_next      = cv_reg;
        cov_next     = cov_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rr_next  = in_rr;
                    acc_next = in_range;
                end
            end
            S_FULL_DROP:
            begin
                span_next = span_reg - SUM_W'(ring_rdata);
                head_next = ptr_inc(head_reg);
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            S_PUSH:
            begin
                wp_next   = ptr_inc(wp_reg);
                cnt_next  = cnt_reg + CNT_W'(1);
                span_next = span_reg + SUM_W'(rr_reg);
            end
            S_EVICT_CHK:
            begin
                if (evict)
                begin
                    span_next = span_reg - SUM_W'(ring_rdata);
                    head_next = ptr_inc(head_reg);
                    cnt_next  = cnt_reg - CNT_W'(1);
                end
            end
            S_FEAT:
            begin
                fv_next      = (cnt_reg >= CNT_W'(MIN_BEATS));
                step_next    = P_NS;
                iss_ptr_next = head_reg;
                iss_cnt_next = '0;
                idx_next     = '0;
                isq_next     = '0;
                sum_next     = '0;
                sumsq_next   = '0;
                dsq_next     = '0;
                pp_next      = '0;
                sumi_next    = '0;
                sumi2_next   = '0;
                nn50_next    = '0;
            end
            S_ACC:
            begin
                if (iss_cnt_reg < cnt_reg)
                begin
                    iss_ptr_next = ptr_inc(iss_ptr_reg);
                    iss_cnt_next = iss_cnt_reg + CNT_W'(1);
                    rd_vld_next  = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    sum_next   = sum_reg + SUM_W'(x);
                    pp_next    = pp_reg + PP_W'(sum_reg) + PP_W'(x);
                    sumsq_next = sumsq_reg + SQ_W'(xsq);
                    sumi_next  = sumi_reg + SI_W'(idx_reg);
                    sumi2_next = sumi2_reg + SI2_W'(isq_reg);
                    isq_next   = isq_reg + (SI_W'(idx_reg) << 1) + SI_W'(1);
                    idx_next   = idx_reg + CNT_W'(1);
                    prev_next  = x;
                    if (idx_reg != '0)
                    begin
                        dsq_next = dsq_reg + SQ_W'(dsqt);
                        if (ad > NN50_LIMIT)
                        begin
                            nn50_next = nn50_reg + CNT_W'(1);
                        end
                    end
                end
            end
            S_WAIT:
            begin
                if (ar_done)
                begin
                    if (step_reg != P_COV)
                    begin
                        step_next = post_step_t'(step_reg + 5'd1);
                    end
                    unique case (step_reg)
                        P_NS:  t1_next = ar_res - DW'(pp_reg);
                        P_NIX: t1_next = ar_res;
                        P_ISUM:
                        begin
                            neg_next = (t1_reg < ar_res);
                            t1_next  = ((t1_reg < ar_res) ? (ar_res - t1_reg)
                                                          : (t1_reg - ar_res)) << 4;
                        end
                        P_NI2: t2_next = ar_res;
                        P_II:  t2_next = t2_reg - ar_res;
                        P_SLOPE:
                        begin
                            if (ar_res >= DW'(SLOPE_LIM))
                            begin
                                slope_next = neg_reg ? SLOPE_NEG_SAT : SLOPE_POS_SAT;
                            end
                            else
                            begin
                                slope_next = neg_reg ? 21'(-ar_res[20:0]) : ar_res[20:0];
                            end
                        end
                        P_NSQ: t1_next = ar_res;
                        P_SS:  t1_next = (t1_reg >= ar_res) ? (t1_reg - ar_res) : '0;
                        P_NN:  t2_next = ar_res;
                        P_VAR: t1_next = ar_res;
                        P_SD:
                        begin
                            sd_next = (ar_res > DW'(SD_SAT)) ? 15'(SD_SAT) : ar_res[14:0];
                        end
                        P_MEAN: mean_next = ar_res[15:0];
                        P_HRN:  t1_next = ar_res;
                        P_HR:
                        begin
                            hr_next = (ar_res > DW'(U16_SAT)) ? 16'(U16_SAT) : ar_res[15:0];
                        end
                        P_RMSQ: t1_next = ar_res;
                        P_RMS:
                        begin
                            rms_next = (ar_res > DW'(U16_SAT)) ? 16'(U16_SAT) : ar_res[15:0];
                        end
                        P_PNN:  pnn_next = ar_res[15:0];
                        P_CV:
                        begin
                            cv_next = (ar_res > DW'(CV_SAT)) ? 15'(CV_SAT) : ar_res[14:0];
                        end
                        P_COV:
                        begin
                            cov_next = (ar_res > DW'(COV_SAT)) ? 16'(COV_SAT)
                                                               : ar_res[15:0];
                        end
                        default: t1_next = t1_reg;
                    endcase
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= P_NS;
            head_reg   <= '0;
            wp_reg     <= '0;
            cnt_reg    <= '0;
            span_reg   <= '0;
            rd_vld_reg <= 1'b0;
            acc_reg    <= 1'b0;
            fv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            head_reg   <= head_next;
            wp_reg     <= wp_next;
            cnt_reg    <= cnt_next;
            span_reg   <= span_next;
            rd_vld_reg <= rd_vld_next;
            acc_reg    <= acc_next;
            fv_reg     <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rr_reg      <= rr_next;
        iss_ptr_reg <= iss_ptr_next;
        iss_cnt_reg <= iss_cnt_next;
        idx_reg     <= idx_next;
        isq_reg     <= isq_next;
        prev_reg    <= prev_next;
        sum_reg     <= sum_next;
        sumsq_reg   <= sumsq_next;
        dsq_reg     <= dsq_next;
        pp_reg      <= pp_next;
        sumi_reg    <= sumi_next;
        sumi2_reg   <= sumi2_next;
        nn50_reg    <= nn50_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        neg_reg     <= neg_next;
        mean_reg    <= mean_next;
        hr_reg      <= hr_next;
        sd_reg      <= sd_next;
        rms_reg     <= rms_next;
        pnn_reg     <= pnn_next;
        slope_reg   <= slope_next;
        cv_reg      <= cv_next;
        cov_reg     <= cov_next;
    end

    always_comb
    begin
        res.accepted       = acc_reg;
        res.features_valid = fv_reg;
        res.mean_rr        = fv_reg ? mean_reg  : '0;
        res.mean_hr        = fv_reg ? hr_reg    : '0;
        res.sdnn           = fv_reg ? sd_reg    : '0;
        res.rmssd          = fv_reg ? rms_reg   : '0;
        res.pnn50          = fv_reg ? pnn_reg   : '0;
        res.rr_slope       = fv_reg ? slope_reg : '0;
        res.hr_cv          = fv_reg ? cv_reg    : '0;
        res.coverage       = fv_reg ? cov_reg   : '0;
    end

endmodule

`default_nettype wire

/* dv/hrv_window_features_tb.sv */
// Testbench for hrv_window_features: directed table plus random RR stream, checked by a predictor
module hrv_window_features_tb;
    import hrv_pkg::*;

    localparam int RING       = 128;
    localparam int STALL_MAX  = 20000;
    localparam int HOLD_LONG  = 4000;
    localparam int PHASE_ITEMS = 300;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_wr_en;
    logic [21:0]  cfg_wr_data;

    hrv_window_features i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // predictor state
    logic [15:0]     beat_mem [RING];
    int unsigned     wr_ptr;
    int unsigned     beat_cnt;
    longint unsigned span16;
    logic [21:0]     win_len;

    hrv_result_t     feature_q [$];
    int              errors;
    int              results_seen;
    int              beats_taken;
    int              valid_seen;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              hold_cycles;
    int              quiet_cycles;
    int              cur_rr;

    typedef struct {
        logic [15:0] rr;
        bit          typed;
        logic        acc;
    } stim_row_t;

    stim_row_t directed [25];

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] beat_at(int unsigned i);
        return beat_mem[(wr_ptr + RING - beat_cnt + i) % RING];
    endfunction

    function automatic longint unsigned window16();
        return ((win_len == 0) ? longint'(WIN_DEFAULT) : longint'(win_len)) * 16;
    endfunction

    function automatic hrv_result_t window_features(logic [15:0] rr);
        hrv_result_t     res;
        longint unsigned n, sum, sumsq, dsq, si, si2, six, nn50, x, prev, ad;
        longint unsigned mean, hr, var_v, sd, rms, cv, cov, mag, q, pnn;
        longint          num, den, slope;
        res = '0;
        if (rr >= RR_LOW && rr <= RR_HIGH)
        begin
            res.accepted = 1'b1;
            if (beat_cnt >= RING)
            begin
                span16   = span16 - beat_at(0);
                beat_cnt = RING - 1;
            end
            beat_mem[wr_ptr] = rr;
            wr_ptr   = (wr_ptr + 1) % RING;
            beat_cnt = beat_cnt + 1;
            span16   = span16 + rr;
            while (beat_cnt > MIN_BEATS && span16 - beat_at(0) > window16())
            begin
                span16   = span16 - beat_at(0);
                beat_cnt = beat_cnt - 1;
            end
        end
        if (beat_cnt < MIN_BEATS)
            return res;
        n = beat_cnt;
        sum = 0; sumsq = 0; dsq = 0; si = 0; si2 = 0; six = 0; nn50 = 0;
        prev = beat_at(0);
        for (int unsigned i = 0; i < beat_cnt; i++)
        begin
            x = beat_at(i);
            sum += x;
            sumsq += x * x;
            si += i;
            si2 += longint'(i) * i;
            six += longint'(i) * x;
            if (i > 0)
            begin
                ad = (x >= prev) ? x - prev : prev - x;
                dsq += ad * ad;
                if (ad > NN50_LIMIT)
                    nn50++;
            end
            prev = x;
        end
        mean = (sum + n / 2) / n;
        hr = (HR_CONST * n + sum / 2) / sum;
        if (hr > U16_SAT)
            hr = U16_SAT;
        var_v = (n * sumsq >= sum * sum) ? (n * sumsq - sum * sum) / (n * n) : 0;
        sd = int_sqrt(var_v);
        if (sd > SD_SAT)
            sd = SD_SAT;
        rms = int_sqrt(dsq / (n - 1));
        if (rms > U16_SAT)
            rms = U16_SAT;
        pnn = nn50 * 32768 / (n - 1);
        num = longint'(n * six) - longint'(si * sum);
        den = longint'(n * si2) - longint'(si * si);
        slope = 0;
        if (den > 0)
        begin
            mag = ((num < 0) ? -num : num) * 16;
            q = (mag + den / 2) / den;
            if (q > SLOPE_LIM)
                q = SLOPE_LIM;
            slope = (num < 0) ? -longint'(q) : longint'(q);
            if (slope > SLOPE_LIM - 1)
                slope = SLOPE_LIM - 1;
        end
        cv = (mean != 0) ? sd * 16384 / mean : 0;
        if (cv > CV_SAT)
            cv = CV_SAT;
        cov = span16 * 32768 / window16();
        if (cov > COV_SAT)
            cov = COV_SAT;
        res.features_valid = 1'b1;
        res.mean_rr  = mean[15:0];
        res.mean_hr  = hr[15:0];
        res.sdnn     = sd[14:0];
        res.rmssd    = rms[15:0];
        res.pnn50    = pnn[15:0];
        res.rr_slope = slope[20:0];
        res.hr_cv    = cv[14:0];
        res.coverage = cov[15:0];
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        errors++;
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, field, got, want);
    endtask

    task automatic check_features(hrv_result_t got);
        hrv_result_t want;
        if (feature_q.size() == 0)
        begin
            errors++;
            $display("[%0t] result with no item pending", $time);
            return;
        end
        want = feature_q.pop_front();
        if (got.accepted != want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
        if (got.features_valid != want.features_valid)
            report_mismatch("features_valid", got.features_valid, want.features_valid);
        if (got.mean_rr != want.mean_rr)
            report_mismatch("mean_rr", got.mean_rr, want.mean_rr);
        if (got.mean_hr != want.mean_hr)
            report_mismatch("mean_hr", got.mean_hr, want.mean_hr);
        if (got.sdnn != want.sdnn)
            report_mismatch("sdnn", got.sdnn, want.sdnn);
        if (got.rmssd != want.rmssd)
            report_mismatch("rmssd", got.rmssd, want.rmssd);
        if (got.pnn50 != want.pnn50)
            report_mismatch("pnn50", got.pnn50, want.pnn50);
        if (got.rr_slope != want.rr_slope)
            report_mismatch("rr_slope", $signed(got.rr_slope), $signed(want.rr_slope));
        if (got.hr_cv != want.hr_cv)
            report_mismatch("hr_cv", got.hr_cv, want.hr_cv);
        if (got.coverage != want.coverage)
            report_mismatch("coverage", got.coverage, want.coverage);
    endtask

    // result side
    always @(posedge clk)
    begin
        hrv_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.accepted       = m_axis_tuser[0];
            got.features_valid = m_axis_tuser[1];
            got.mean_rr  = m_axis_tdata[15:0];
            got.mean_hr  = m_axis_tdata[31:16];
            got.sdnn     = m_axis_tdata[46:32];
            got.rmssd    = m_axis_tdata[62:47];
            got.pnn50    = m_axis_tdata[78:63];
            got.rr_slope = m_axis_tdata[99:79];
            got.hr_cv    = m_axis_tdata[114:100];
            got.coverage = m_axis_tdata[130:115];
            results_seen++;
            if (got.features_valid)
                valid_seen++;
            check_features(got);
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("timeout: no item moved for %0d cycles", STALL_MAX);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_rr(logic [15:0] rr, bit typed, logic acc);
        hrv_result_t pred;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rr;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = window_features(rr);
        if (pred.accepted)
            beats_taken++;
        if (typed)
        begin
            pred = '0;
            pred.accepted = acc;
        end
        feature_q.push_back(pred);
    endtask

    task automatic write_window(logic [21:0] value);
        s_axis_tvalid <= 1'b0;
        wait (feature_q.size() == 0);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        win_len = value;
    endtask

    function automatic logic [15:0] next_rr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'($urandom_range(0, 65535));
        if (r < 14)
            case ($urandom_range(0, 3))
                0: return 16'(RR_LOW - 1);
                1: return RR_LOW;
                2: return RR_HIGH;
                default: return 16'(RR_HIGH + 1);
            endcase
        if (r < 20)
            cur_rr = $urandom_range(RR_LOW, RR_HIGH);
        else
            cur_rr = cur_rr + $urandom_range(0, 2400) - 1200;
        if (cur_rr < RR_LOW)
            cur_rr = RR_LOW;
        if (cur_rr > RR_HIGH)
            cur_rr = RR_HIGH;
        return 16'(cur_rr);
    endfunction

    task automatic run_phase(logic [21:0] win, int idle, int stall, int hold);
        write_window(win);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        hold_cycles    = hold;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_rr(next_rr(), 1'b0, 1'b0);
    endtask

    initial
    begin
        errors = 0; results_seen = 0; beats_taken = 0; valid_seen = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0; quiet_cycles = 0;
        cur_rr = 12000;
        wr_ptr = 0; beat_cnt = 0; span16 = 0; win_len = WIN_DEFAULT;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;

        directed[0] = '{16'd0,     1'b1, 1'b0};
        directed[1] = '{16'(RR_LOW - 1), 1'b1, 1'b0};
        directed[2] = '{RR_LOW,    1'b1, 1'b1};
        directed[3] = '{RR_HIGH,   1'b1, 1'b1};
        directed[4] = '{16'(RR_HIGH + 1), 1'b1, 1'b0};
        directed[5] = '{16'hFFFF,  1'b1, 1'b0};
        // alternate extremes for large successive differences, then flat beats
        for (int i = 6; i < 25; i++)
            directed[i] = '{(i < 16) ? ((i % 2) ? RR_LOW : RR_HIGH) : 16'd12800, 1'b0, 1'b0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_rr(directed[i].rr, directed[i].typed, directed[i].acc);

        run_phase(22'd0,       0,  0,  0);
        run_phase(22'd1,       80, 0,  0);
        run_phase(22'h3FFFFF,  0,  80, HOLD_LONG);
        run_phase(22'd15000,   7,  7,  0);
        run_phase(WIN_DEFAULT, 0,  0,  0);

        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        wait (feature_q.size() == 0);
        repeat (1000) @(posedge clk);
        if (feature_q.size() != 0)
        begin
            errors++;
            $display("%0d expected results never arrived", feature_q.size());
        end
        $display("run covered %0d results, %0d stored beats, %0d with features valid",
                 results_seen, beats_taken, valid_seen);
        $display("window settings: zero, 1 ms, maximum, 15000 ms and default");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
